// ===== sv/path_oram_access_controller_defines.svh =====
// Assertion macros shared by the Path ORAM access controller.
`ifndef PATH_ORAM_ACCESS_CONTROLLER_DEFINES_SVH
`define PATH_ORAM_ACCESS_CONTROLLER_DEFINES_SVH
// Implication checked at every rising clock edge outside reset.
`define PORAM_ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define PORAM_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`endif

// ===== sv/poram_pkg.sv =====
// Shared types and constants of the Path ORAM access controller.
package poram_pkg;
    localparam int unsigned OPCODE_BITS = 1;
    localparam int unsigned INDEX_BITS  = 8;
    localparam int unsigned LEAF_BITS   = 8;
    localparam int unsigned DATA_BITS   = 32;
    localparam int unsigned FILL_BITS   = 8;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAP_RD,
        ST_MAP_WR,
        ST_PATH_RD,
        ST_PATH_WAIT,
        ST_FIND,
        ST_FIND_WAIT,
        ST_SERVE,
        ST_EV_START,
        ST_EV_SCAN,
        ST_EV_WAIT,
        ST_EV_TAKE,
        ST_EV_FILL,
        ST_EV_DONE,
        ST_RESULT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_step;
        logic capture_in;
        logic map_write;
        logic path_take;
        logic find_take;
        logic serve;
        logic ev_start;
        logic ev_take;
        logic ev_fill;
        logic ev_done;
        logic result_load;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic idx_ok;
        logic path_last;
        logic find_last;
        logic ev_last;
        logic fill_last;
        logic level_last;
    } t_status;
endpackage

// ===== sv/poram_if.sv =====
// Valid/ready channel interface carrying the access and result items.
interface poram_if #(
    parameter int unsigned WIDTH = 8
) (
    input logic i_clk
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/poram_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
module poram_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/poram_datapath.sv =====
// Datapath: position map, tree and stash memories with their counters.
module poram_datapath #(
    parameter int unsigned TREE_LEVELS  = 9,
    parameter int unsigned BUCKET_SLOTS = 4,
    parameter int unsigned BLOCK_COUNT  = 256,
    parameter int unsigned STASH_DEPTH  = 128,
    parameter int unsigned PAYLOAD_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  poram_pkg::t_cmd                   i_cmd,
    output poram_pkg::t_status                o_status,
    input  logic [poram_pkg::OPCODE_BITS-1:0] i_opcode,
    input  logic [poram_pkg::INDEX_BITS-1:0]  i_block_index,
    input  logic [poram_pkg::LEAF_BITS-1:0]   i_fresh_leaf,
    input  logic [poram_pkg::DATA_BITS-1:0]   i_write_data,
    output logic [poram_pkg::DATA_BITS-1:0]   o_read_data,
    output logic                              o_hit,
    output logic [poram_pkg::FILL_BITS-1:0]   o_stash_fill,
    output logic                              o_overflow
);
    import poram_pkg::*;

    localparam int unsigned LB = TREE_LEVELS - 1;            // leaf bits
    localparam int unsigned BUCKETS = (1 << TREE_LEVELS) - 1;
    localparam int unsigned SLOTS = BUCKETS * BUCKET_SLOTS;
    localparam int unsigned SA = $clog2(SLOTS);
    localparam int unsigned BA = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
    localparam int unsigned QA = $clog2(STASH_DEPTH);
    localparam int unsigned QC = $clog2(STASH_DEPTH + 1);
    localparam int unsigned SB = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
    localparam int unsigned SC = $clog2(BUCKET_SLOTS + 1);
    localparam int unsigned LV = $clog2(TREE_LEVELS);
    localparam int unsigned TW = BA + 1;                      // valid + index
    localparam int unsigned CLR = (SLOTS > BLOCK_COUNT) ? SLOTS : BLOCK_COUNT;
    localparam int unsigned CA = $clog2(CLR);
    localparam int unsigned LBW = (LB > 0) ? LB : 1;

    function automatic logic [SA-1:0] bucket_base(input logic [LBW-1:0] leaf,
                                                  input logic [LV-1:0] lvl);
        logic [SA-1:0] b;
        b = SA'((1 << lvl) - 1) + SA'(leaf >> (LB - lvl));
        return SA'(b * BUCKET_SLOTS);
    endfunction

    // Input item registers.
    logic            r_op;
    logic [BA-1:0]   r_idx;
    logic [LBW-1:0]  r_fresh, r_old;
    logic [PAYLOAD_BITS-1:0] r_wdata;
    logic            r_idx_ok;

    // Counters.
    logic [CA-1:0]   r_clr;
    logic [LV-1:0]   r_lvl;
    logic [SB-1:0]   r_slot;
    logic [QC-1:0]   r_used, r_k, r_keep, r_found;
    logic [SC-1:0]   r_taken;
    logic            r_have, r_ovf;
    logic [PAYLOAD_BITS-1:0] r_rdata;
    logic            r_serve_d;

    // Result item registers.
    logic [DATA_BITS-1:0] r_out_rdata;
    logic                 r_out_hit;
    logic [FILL_BITS-1:0] r_out_fill;
    logic                 r_out_ovf;

    // Memories.
    logic            map_we;
    logic [BA-1:0]   map_wa, map_ra;
    logic [LBW-1:0]  map_wd, map_rd;
    logic            tag_we;
    logic [SA-1:0]   tag_wa, tag_ra;
    logic [TW-1:0]   tag_wd, tag_rd;
    logic            pay_we;
    logic [SA-1:0]   pay_wa;
    logic [PAYLOAD_BITS-1:0] pay_wd, pay_rd;
    logic            stag_we;
    logic [QA-1:0]   stag_wa, stag_ra;
    logic [TW-1:0]   stag_wd, stag_rd;
    logic            spay_we;
    logic [QA-1:0]   spay_wa;
    logic [PAYLOAD_BITS-1:0] spay_wd, spay_rd;
    // Leaf map copy used while scanning the stash during eviction.
    logic [LBW-1:0]  map2_rd;
    logic [BA-1:0]   map2_ra;

    poram_ram #(.WIDTH(LBW), .DEPTH(BLOCK_COUNT)) u_map (
        .i_clk(i_clk), .i_we(map_we), .i_waddr(map_wa), .i_wdata(map_wd),
        .i_raddr(map_ra), .o_rdata(map_rd));
    poram_ram #(.WIDTH(LBW), .DEPTH(BLOCK_COUNT)) u_map2 (
        .i_clk(i_clk), .i_we(map_we), .i_waddr(map_wa), .i_wdata(map_wd),
        .i_raddr(map2_ra), .o_rdata(map2_rd));
    poram_ram #(.WIDTH(TW), .DEPTH(SLOTS)) u_tag (
        .i_clk(i_clk), .i_we(tag_we), .i_waddr(tag_wa), .i_wdata(tag_wd),
        .i_raddr(tag_ra), .o_rdata(tag_rd));
    poram_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(SLOTS)) u_pay (
        .i_clk(i_clk), .i_we(pay_we), .i_waddr(pay_wa), .i_wdata(pay_wd),
        .i_raddr(tag_ra), .o_rdata(pay_rd));
    poram_ram #(.WIDTH(TW), .DEPTH(STASH_DEPTH)) u_stag (
        .i_clk(i_clk), .i_we(stag_we), .i_waddr(stag_wa), .i_wdata(stag_wd),
        .i_raddr(stag_ra), .o_rdata(stag_rd));
    poram_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(STASH_DEPTH)) u_spay (
        .i_clk(i_clk), .i_we(spay_we), .i_waddr(spay_wa), .i_wdata(spay_wd),
        .i_raddr(stag_ra), .o_rdata(spay_rd));

    logic [SA-1:0] path_addr;
    logic [SA-1:0] ev_base;
    logic          k_live;
    logic          fits;
    logic          tag_valid_rd;

    assign path_addr = bucket_base(r_old, r_lvl) + SA'(r_slot);
    assign ev_base = bucket_base(r_old, r_lvl);
    assign k_live = (r_k < r_used);
    assign tag_valid_rd = tag_rd[TW-1];
    // The leaf map copy is addressed by the registered stash tag, so its
    // data arrives in the cycle after the stash entry itself.
    assign map2_ra = stag_rd[BA-1:0];
    assign fits = (r_taken < SC'(BUCKET_SLOTS))
                  && (bucket_base(map2_rd, r_lvl) == ev_base);

    // Memory port steering.
    always_comb begin
        map_we = 1'b0; map_wa = r_idx; map_wd = r_fresh; map_ra = r_idx;
        tag_we = 1'b0; tag_wa = path_addr; tag_wd = '0; tag_ra = path_addr;
        pay_we = 1'b0; pay_wa = ev_base + SA'(r_taken); pay_wd = spay_rd;
        stag_we = 1'b0; stag_wa = r_used[QA-1:0]; stag_wd = '0;
        stag_ra = r_k[QA-1:0];
        spay_we = 1'b0; spay_wa = r_used[QA-1:0]; spay_wd = pay_rd;
        if (i_cmd.clear_step) begin
            tag_we = (r_clr < CA'(SLOTS));
            tag_wa = r_clr[SA-1:0];
            map_we = (r_clr < CA'(BLOCK_COUNT));
            map_wa = r_clr[BA-1:0];
            map_wd = '0;
        end
        if (i_cmd.map_write) begin
            map_we = 1'b1;
        end
        if (i_cmd.path_take && tag_valid_rd) begin
            tag_we = 1'b1;
            tag_wd = '0;
            if (r_used < QC'(STASH_DEPTH)) begin
                stag_we = 1'b1;
                stag_wd = tag_rd;
                spay_we = 1'b1;
                spay_wd = pay_rd;
            end
        end
        if (i_cmd.serve && r_op == OP_WRITE) begin
            if (r_have) begin
                spay_we = 1'b1;
                spay_wa = r_found[QA-1:0];
                spay_wd = r_wdata;
            end else if (r_used < QC'(STASH_DEPTH)) begin
                stag_we = 1'b1;
                stag_wd = {1'b1, r_idx};
                spay_we = 1'b1;
                spay_wd = r_wdata;
            end
        end
        if (i_cmd.serve) begin
            stag_ra = r_found[QA-1:0];
        end
        if (i_cmd.ev_take) begin
            if (fits) begin
                tag_we = 1'b1;
                tag_wa = ev_base + SA'(r_taken);
                tag_wd = {1'b1, stag_rd[BA-1:0]};
                pay_we = 1'b1;
            end else begin
                stag_we = 1'b1;
                stag_wa = r_keep[QA-1:0];
                stag_wd = stag_rd;
                spay_we = 1'b1;
                spay_wa = r_keep[QA-1:0];
                spay_wd = spay_rd;
            end
        end
        if (i_cmd.ev_fill) begin
            tag_we = 1'b1;
            tag_wa = ev_base + SA'(r_taken);
            tag_wd = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
            r_used <= '0;
            r_ovf <= 1'b0;
            r_lvl <= '0;
            r_slot <= '0;
            r_k <= '0;
            r_keep <= '0;
            r_taken <= '0;
            r_have <= 1'b0;
            r_serve_d <= 1'b0;
            r_out_rdata <= '0;
            r_out_hit <= 1'b0;
            r_out_fill <= '0;
            r_out_ovf <= 1'b0;
        end else begin
            r_serve_d <= i_cmd.serve;
            if (i_cmd.clear_step) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.capture_in) begin
                r_op <= i_opcode;
                r_idx <= BA'(i_block_index);
                r_idx_ok <= (32'(i_block_index) < BLOCK_COUNT);
                r_fresh <= LBW'(i_fresh_leaf);
                r_wdata <= PAYLOAD_BITS'(i_write_data);
                r_rdata <= '0;
                r_have <= 1'b0;
                r_lvl <= '0;
                r_slot <= '0;
                r_k <= '0;
            end
            if (i_cmd.map_write) begin
                r_old <= map_rd;
            end
            if (i_cmd.path_take) begin
                if (tag_valid_rd) begin
                    if (r_used < QC'(STASH_DEPTH)) r_used <= r_used + 1'b1;
                    else r_ovf <= 1'b1;
                end
                if (r_slot == SB'(BUCKET_SLOTS - 1)) begin
                    r_slot <= '0;
                    r_lvl <= r_lvl + 1'b1;
                end else begin
                    r_slot <= r_slot + 1'b1;
                end
            end
            if (i_cmd.find_take) begin
                if (k_live && !r_have && stag_rd[TW-1] && stag_rd[BA-1:0] == r_idx) begin
                    r_have <= 1'b1;
                    r_found <= r_k;
                end
                r_k <= r_k + 1'b1;
            end
            if (i_cmd.serve) begin
                if (r_op == OP_WRITE && !r_have) begin
                    if (r_used < QC'(STASH_DEPTH)) r_used <= r_used + 1'b1;
                    else r_ovf <= 1'b1;
                end
                r_lvl <= LV'(TREE_LEVELS - 1);
            end
            if (i_cmd.ev_start) begin
                r_k <= '0;
                r_keep <= '0;
                r_taken <= '0;
            end
            if (i_cmd.ev_take) begin
                if (fits) r_taken <= r_taken + 1'b1;
                else r_keep <= r_keep + 1'b1;
                r_k <= r_k + 1'b1;
            end
            if (i_cmd.ev_fill) begin
                r_taken <= r_taken + 1'b1;
            end
            if (i_cmd.ev_done) begin
                r_used <= r_keep;
                r_lvl <= r_lvl - 1'b1;
            end
            // Only the cycle right after serve holds the payload of the hit.
            if (i_cmd.result_load && r_serve_d) begin
                if (r_op == OP_READ && r_have) r_rdata <= spay_rd;
            end
            if (i_cmd.out_load) begin
                r_out_rdata <= DATA_BITS'(r_rdata);
                r_out_hit <= r_have;
                r_out_fill <= (r_used > QC'(255)) ? FILL_BITS'(255) : FILL_BITS'(r_used);
                r_out_ovf <= r_ovf;
            end
        end
    end

    assign o_status.clear_last = (r_clr == CA'(CLR - 1));
    assign o_status.idx_ok     = r_idx_ok;
    assign o_status.path_last  = (r_lvl == LV'(TREE_LEVELS - 1))
                                 && (r_slot == SB'(BUCKET_SLOTS - 1));
    assign o_status.find_last  = (r_k >= r_used) || r_have;
    assign o_status.ev_last    = (r_k >= r_used);
    assign o_status.fill_last  = (r_taken >= SC'(BUCKET_SLOTS));
    assign o_status.level_last = (r_lvl == '0);

    assign o_read_data  = r_out_rdata;
    assign o_hit        = r_out_hit;
    assign o_stash_fill = r_out_fill;
    assign o_overflow   = r_out_ovf;
endmodule

// ===== sv/poram_ctrl.sv =====
// Controller state machine sequencing one access through the datapath.
module poram_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output poram_pkg::t_cmd    o_cmd,
    input  poram_pkg::t_status i_status,
    output logic               o_busy
);
    import poram_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_status.clear_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture_in = 1'b1;
                    n_state = ST_MAP_RD;
                end
            end
            ST_MAP_RD: begin
                n_state = i_status.idx_ok ? ST_MAP_WR : ST_RESULT;
            end
            ST_MAP_WR: begin
                o_cmd.map_write = 1'b1;
                n_state = ST_PATH_RD;
            end
            ST_PATH_RD: begin
                n_state = ST_PATH_WAIT;
            end
            ST_PATH_WAIT: begin
                o_cmd.path_take = 1'b1;
                n_state = i_status.path_last ? ST_FIND : ST_PATH_RD;
            end
            ST_FIND: begin
                n_state = i_status.find_last ? ST_SERVE : ST_FIND_WAIT;
            end
            ST_FIND_WAIT: begin
                o_cmd.find_take = 1'b1;
                n_state = ST_FIND;
            end
            ST_SERVE: begin
                o_cmd.serve = 1'b1;
                n_state = ST_EV_START;
            end
            ST_EV_START: begin
                o_cmd.result_load = 1'b1;
                o_cmd.ev_start = 1'b1;
                n_state = ST_EV_SCAN;
            end
            ST_EV_SCAN: begin
                n_state = i_status.ev_last ? ST_EV_FILL : ST_EV_WAIT;
            end
            // The stash entry is out; its leaf is looked up in this cycle.
            ST_EV_WAIT: begin
                n_state = ST_EV_TAKE;
            end
            ST_EV_TAKE: begin
                o_cmd.ev_take = 1'b1;
                n_state = ST_EV_SCAN;
            end
            ST_EV_FILL: begin
                if (i_status.fill_last) begin
                    n_state = ST_EV_DONE;
                end else begin
                    o_cmd.ev_fill = 1'b1;
                end
            end
            ST_EV_DONE: begin
                o_cmd.ev_done = 1'b1;
                n_state = (i_status.level_last) ? ST_RESULT : ST_EV_START;
            end
            ST_RESULT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_busy = (r_state != ST_IDLE);
endmodule

// ===== sv/path_oram_access_controller.sv =====
// Path ORAM access controller: top level joining controller and datapath.
// The stash scans of the lookup and of each eviction level set the access time.
// One item at a time; the next item is taken while a result waits in its register.
// After reset a clearing pass over max(buckets*slots, blocks) entries runs before the
// first item is taken.
`include "path_oram_access_controller_defines.svh"
module path_oram_access_controller #(
    parameter int unsigned TREE_LEVELS  = 9,
    parameter int unsigned BUCKET_SLOTS = 4,
    parameter int unsigned BLOCK_COUNT  = 256,
    parameter int unsigned STASH_DEPTH  = 128,
    parameter int unsigned PAYLOAD_BITS = 32
) (
    input logic  i_clk,
    input logic  i_rst_n,
    poram_if.sink   i_access,
    poram_if.source o_result
);
    import poram_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    busy;
    logic    in_ready;
    logic    out_valid;
    logic [DATA_BITS-1:0] read_data;
    logic                 hit;
    logic [FILL_BITS-1:0] stash_fill;
    logic                 overflow;

    poram_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_access.valid), .o_in_ready(in_ready),
        .o_out_valid(out_valid), .i_out_ready(o_result.ready),
        .o_cmd(cmd), .i_status(status), .o_busy(busy));

    poram_datapath #(
        .TREE_LEVELS(TREE_LEVELS), .BUCKET_SLOTS(BUCKET_SLOTS),
        .BLOCK_COUNT(BLOCK_COUNT), .STASH_DEPTH(STASH_DEPTH),
        .PAYLOAD_BITS(PAYLOAD_BITS)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_status(status),
        .i_opcode(i_access.data[48:48]),
        .i_block_index(i_access.data[47:40]),
        .i_fresh_leaf(i_access.data[39:32]),
        .i_write_data(i_access.data[31:0]),
        .o_read_data(read_data), .o_hit(hit),
        .o_stash_fill(stash_fill), .o_overflow(overflow));

    assign i_access.ready = in_ready;
    assign o_result.valid = out_valid;
    assign o_result.data  = {overflow, stash_fill, hit, read_data};

    `PORAM_ASSERT_IMPL(a_ready_idle, i_clk, i_rst_n, in_ready, !busy,
        "input ready while busy")
    `PORAM_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_access.valid && in_ready,
        busy, "accepted item did not start work")
    `PORAM_ASSERT_IMPL(a_out_when_idle, i_clk, i_rst_n, out_valid && busy,
        !$rose(out_valid), "result shown mid-access")
endmodule

// ===== tb/sv/path_oram_access_controller_tb.sv =====
// Testbench of the Path ORAM access controller: directed table, then random accesses.
`timescale 1ns / 100ps
module path_oram_access_controller_tb;
    import poram_pkg::*;

    localparam int unsigned LEVELS     = 9;
    localparam int unsigned SLOTS      = 4;
    localparam int unsigned BLOCKS     = 256;
    localparam int unsigned STASH_MAX  = 128;
    localparam int unsigned TREE_SLOTS = ((1 << LEVELS) - 1) * SLOTS;
    localparam int unsigned RANDOM_ITEMS = 480;
    localparam int unsigned LONG_HOLD    = 4000;
    localparam int unsigned IDLE_LIMIT   = 50000;

    typedef struct packed {
        logic                 op;
        logic [INDEX_BITS-1:0] idx;
        logic [LEAF_BITS-1:0]  leaf;
        logic [DATA_BITS-1:0]  wdata;
    } access_t;

    typedef struct packed {
        logic                 ovf;
        logic [FILL_BITS-1:0] fill;
        logic                 hit;
        logic [DATA_BITS-1:0] rdata;
    } result_t;

    typedef struct {
        access_t acc;
        bit      typed;
        result_t want;
    } plan_row_t;

    logic i_clk;
    logic i_rst_n;

    poram_if #(.WIDTH($bits(access_t))) acc_if (i_clk);
    poram_if #(.WIDTH($bits(result_t))) res_if (i_clk);

    path_oram_access_controller dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_access (acc_if),
        .o_result (res_if)
    );

    // Shadow copy of the position map, tree and stash.
    logic [LEAF_BITS-1:0]  leaf_of [BLOCKS];
    bit                    slot_full [TREE_SLOTS];
    logic [INDEX_BITS-1:0] slot_block [TREE_SLOTS];
    logic [DATA_BITS-1:0]  slot_data [TREE_SLOTS];
    logic [INDEX_BITS-1:0] stash_block [STASH_MAX];
    logic [DATA_BITS-1:0]  stash_data [STASH_MAX];
    int unsigned           stash_count;
    bit                    stash_overflowed;

    result_t   pending_results[$];
    plan_row_t typed_rows[$];
    plan_row_t plan[$];
    int        errors = 0;
    int        idle_cycles = 0;
    bit        hold_request;
    bit        quiet;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic int unsigned bucket_of(input logic [LEAF_BITS-1:0] leaf,
                                              input int unsigned lvl);
        return ((1 << lvl) - 1) + (int'(leaf) >> (LEVELS - 1 - lvl));
    endfunction

    function automatic void stash_insert(input logic [INDEX_BITS-1:0] blk,
                                         input logic [DATA_BITS-1:0] data);
        if (stash_count >= STASH_MAX) begin
            stash_overflowed = 1'b1;
        end else begin
            stash_block[stash_count] = blk;
            stash_data[stash_count]  = data;
            stash_count++;
        end
    endfunction

    // One full access: path read, serve from the stash, greedy eviction.
    function automatic result_t oram_access(input access_t a);
        result_t               r;
        logic [LEAF_BITS-1:0]  old_leaf;
        int unsigned           base;
        int unsigned           bkt;
        int unsigned           taken;
        int unsigned           keep;
        int                    found;
        r        = '0;
        found    = -1;
        old_leaf = leaf_of[a.idx];
        leaf_of[a.idx] = a.leaf;
        for (int unsigned lvl = 0; lvl < LEVELS; lvl++) begin
            base = bucket_of(old_leaf, lvl) * SLOTS;
            for (int unsigned s = 0; s < SLOTS; s++) begin
                if (slot_full[base + s]) begin
                    stash_insert(slot_block[base + s], slot_data[base + s]);
                    slot_full[base + s] = 1'b0;
                end
            end
        end
        for (int unsigned k = 0; k < stash_count; k++) begin
            if (stash_block[k] == a.idx) begin
                found = k;
                break;
            end
        end
        r.hit = (found >= 0);
        if (a.op == OP_WRITE) begin
            if (found >= 0) stash_data[found] = a.wdata;
            else stash_insert(a.idx, a.wdata);
        end else if (found >= 0) begin
            r.rdata = stash_data[found];
        end
        for (int lvl = LEVELS - 1; lvl >= 0; lvl--) begin
            bkt   = bucket_of(old_leaf, lvl);
            base  = bkt * SLOTS;
            taken = 0;
            keep  = 0;
            for (int unsigned k = 0; k < stash_count; k++) begin
                if (taken < SLOTS && bucket_of(leaf_of[stash_block[k]], lvl) == bkt) begin
                    slot_full[base + taken]  = 1'b1;
                    slot_block[base + taken] = stash_block[k];
                    slot_data[base + taken]  = stash_data[k];
                    taken++;
                end else begin
                    stash_block[keep] = stash_block[k];
                    stash_data[keep]  = stash_data[k];
                    keep++;
                end
            end
            for (; taken < SLOTS; taken++) slot_full[base + taken] = 1'b0;
            stash_count = keep;
        end
        r.fill = FILL_BITS'(stash_count);
        r.ovf  = stash_overflowed;
        return r;
    endfunction

    // Prediction on every accepted access, comparison on every accepted result.
    always @(posedge i_clk) begin
        plan_row_t row;
        result_t   got;
        result_t   want;
        result_t   model;
        if (acc_if.valid && acc_if.ready) begin
            row   = typed_rows.pop_front();
            model = oram_access(access_t'(acc_if.data));
            want  = row.typed ? row.want : model;
            pending_results = {pending_results, want};
        end
        if (res_if.valid && res_if.ready) begin
            got = result_t'(res_if.data);
            if (pending_results.size() == 0) begin
                $error("result item with nothing expected: %h", got);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (got.rdata !== want.rdata) begin
                    $error("read_data expected %h actual %h", want.rdata, got.rdata);
                    errors++;
                end
                if (got.hit !== want.hit) begin
                    $error("hit expected %b actual %b", want.hit, got.hit);
                    errors++;
                end
                if (got.fill !== want.fill) begin
                    $error("stash_fill expected %0d actual %0d", want.fill, got.fill);
                    errors++;
                end
                if (got.ovf !== want.ovf) begin
                    $error("overflow expected %b actual %b", want.ovf, got.ovf);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles in which neither side moves an item.
    always @(posedge i_clk) begin
        if ((acc_if.valid && acc_if.ready) || (res_if.valid && res_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result receiver with random stalls and one long hold-off on request.
    initial begin
        int unsigned n;
        bit          held;
        held = 1'b0;
        res_if.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_request && !held) begin
                held = 1'b1;
                res_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                n = quiet ? 0 : $urandom_range(0, 16);
                if (n > 0) begin
                    res_if.ready <= 1'b0;
                    repeat (n) @(posedge i_clk);
                end
                res_if.ready <= 1'b1;
                do @(posedge i_clk); while (!res_if.valid);
            end
        end
    end

    task automatic send_access(input access_t a, input bit typed, input result_t want);
        int unsigned gap;
        plan_row_t   row;
        gap = quiet ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            acc_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        row.acc   = a;
        row.typed = typed;
        row.want  = want;
        typed_rows = {typed_rows, row};
        acc_if.valid <= 1'b1;
        acc_if.data  <= a;
        do @(posedge i_clk); while (!acc_if.ready);
    endtask

    function automatic plan_row_t mk(input logic op, input logic [7:0] idx,
                                     input logic [7:0] leaf, input logic [31:0] wd);
        plan_row_t p;
        p.acc   = '{op: op, idx: idx, leaf: leaf, wdata: wd};
        p.typed = 1'b0;
        p.want  = '0;
        return p;
    endfunction

    initial begin
        plan_row_t p;
        access_t   a;
        hold_request = 1'b0;
        quiet        = 1'b0;
        stash_count  = 0;
        stash_overflowed = 1'b0;
        foreach (leaf_of[i]) leaf_of[i] = '0;
        foreach (slot_full[i]) slot_full[i] = 1'b0;
        acc_if.valid = 1'b0;
        acc_if.data  = '0;
        i_rst_n      = 1'b0;

        // Reset state: a read misses, then a write and read at the extremes.
        p = mk(OP_READ, 8'd0, 8'd0, 32'h0);
        p.typed = 1'b1; p.want = '{ovf: 1'b0, fill: 8'd0, hit: 1'b0, rdata: 32'h0};
        plan = {plan, p};
        p = mk(OP_WRITE, 8'd255, 8'd255, 32'hFFFF_FFFF);
        p.typed = 1'b1; p.want = '{ovf: 1'b0, fill: 8'd0, hit: 1'b0, rdata: 32'h0};
        plan = {plan, p};
        p = mk(OP_READ, 8'd255, 8'd0, 32'h1234_5678);
        p.typed = 1'b1;
        p.want = '{ovf: 1'b0, fill: 8'd0, hit: 1'b1, rdata: 32'hFFFF_FFFF};
        plan = {plan, p};
        p = mk(OP_WRITE, 8'd0, 8'd0, 32'h0000_0000);   plan = {plan, p};
        p = mk(OP_WRITE, 8'd0, 8'd128, 32'hFFFF_FFFF); plan = {plan, p};
        p = mk(OP_READ, 8'd0, 8'd127, 32'h0);          plan = {plan, p};
        p = mk(OP_WRITE, 8'd128, 8'd128, 32'h8000_0000); plan = {plan, p};
        p = mk(OP_WRITE, 8'd127, 8'd127, 32'h7FFF_FFFF); plan = {plan, p};
        p = mk(OP_READ, 8'd200, 8'd1, 32'hFFFF_FFFF);  plan = {plan, p};
        p = mk(OP_READ, 8'd200, 8'd2, 32'h0);          plan = {plan, p};
        p = mk(OP_READ, 8'd128, 8'd255, 32'h0);        plan = {plan, p};
        p = mk(OP_READ, 8'd127, 8'd0, 32'h0);          plan = {plan, p};
        p = mk(OP_WRITE, 8'd255, 8'd0, 32'h5555_5555); plan = {plan, p};
        p = mk(OP_READ, 8'd255, 8'd170, 32'hAAAA_AAAA); plan = {plan, p};
        for (int i = 1; i <= 6; i++) begin
            p = mk(OP_WRITE, 8'(i), 8'd0, 32'h1111_1111 * i);
            plan = {plan, p};
        end
        for (int i = 1; i <= 6; i++) begin
            p = mk(OP_READ, 8'(i), 8'(i * 40), 32'h0);
            plan = {plan, p};
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) send_access(plan[i].acc, plan[i].typed, plan[i].want);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 100) hold_request = 1'b1;
            if (i == 250) begin
                acc_if.valid <= 1'b0;
                do @(posedge i_clk); while (pending_results.size() != 0);
            end
            quiet = (i >= 300 && i < 340);
            a.op    = 1'($urandom_range(0, 1));
            // Mostly a small working set so that reads hit and writes update.
            a.idx   = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 15))
                                                   : 8'($urandom_range(0, 255));
            a.leaf  = 8'($urandom_range(0, 255));
            a.wdata = $urandom;
            send_access(a, 1'b0, '0);
        end
        quiet = 1'b0;
        acc_if.valid <= 1'b0;

        do @(posedge i_clk); while (pending_results.size() != 0);
        repeat (100) @(posedge i_clk);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
